FILE: rtl/lhp_pkg.sv
// shared types, constants and bucket bound table for the latency histogram
`timescale 1ns / 1ps
`default_nettype none

package lhp_pkg;

   localparam int NUM_BUCKETS = 155;
   localparam int NUM_FINITE  = 153;
   localparam int BOUND_WIDTH = 34;
   localparam int IDX_WIDTH   = 8;
   localparam int FRAC_WIDTH  = 17;
   localparam int EXP_WIDTH   = 4;
   localparam int OP_WIDTH    = 2;
   localparam int SUM_WIDTH   = 64;
   localparam int DIV_STEPS   = 30;
   localparam int STEP_WIDTH  = 5;
   localparam int CSR_AWIDTH  = 3;
   localparam int CSR_DWIDTH  = 32;

   localparam logic [FRAC_WIDTH-1:0] FRAC_ONE  = 17'h10000;
   localparam logic                  CSR_SCALE = 1'b0;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_ADD   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_SCALE,
      F_SEARCH,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_ADD,
      B_THR,
      B_RD,
      B_CHK,
      B_DIV,
      B_FIN,
      B_EMIT
   } back_state_type;

   // bounds 1..9, then per decade the mantissas 1.0 .. 9.0
   function automatic logic [BOUND_WIDTH-1:0] bound_at(input logic [IDX_WIDTH-1:0] i);
      logic [IDX_WIDTH-1:0]   j;
      logic [BOUND_WIDTH-1:0] m;
      logic [BOUND_WIDTH-1:0] p;
      j = i - 8'd9;
      unique case (j[3:0])
         4'd0:    m = 34'd10;
         4'd1:    m = 34'd12;
         4'd2:    m = 34'd14;
         4'd3:    m = 34'd16;
         4'd4:    m = 34'd18;
         4'd5:    m = 34'd20;
         4'd6:    m = 34'd25;
         4'd7:    m = 34'd30;
         4'd8:    m = 34'd35;
         4'd9:    m = 34'd40;
         4'd10:   m = 34'd45;
         4'd11:   m = 34'd50;
         4'd12:   m = 34'd60;
         4'd13:   m = 34'd70;
         4'd14:   m = 34'd80;
         default: m = 34'd90;
      endcase
      unique case (j[7:4])
         4'd0:    p = 34'd1;
         4'd1:    p = 34'd10;
         4'd2:    p = 34'd100;
         4'd3:    p = 34'd1000;
         4'd4:    p = 34'd10000;
         4'd5:    p = 34'd100000;
         4'd6:    p = 34'd1000000;
         4'd7:    p = 34'd10000000;
         4'd8:    p = 34'd100000000;
         default: p = 34'd0;
      endcase
      if (i < 8'd9) begin
         bound_at = BOUND_WIDTH'(i) + 34'd1;
      end else begin
         bound_at = m * p;
      end
   endfunction

endpackage

`default_nettype wire

FILE: rtl/lhp_front.sv
// front end: takes items, scales add samples and finds their bucket
`timescale 1ns / 1ps
`default_nettype none

module lhp_front #(
   parameter int VALUE_WIDTH = 48
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire  [lhp_pkg::OP_WIDTH-1:0]    req_opcode,
   input  wire  [31:0]                     req_sample,
   input  wire  [lhp_pkg::FRAC_WIDTH-1:0]  req_percentile_fraction,
   input  wire  [lhp_pkg::EXP_WIDTH-1:0]   scale_exponent,
   input  wire                             push_full,
   output logic                            push_valid,
   output logic [lhp_pkg::OP_WIDTH-1:0]    push_op,
   output logic [lhp_pkg::IDX_WIDTH-1:0]   push_idx,
   output logic [lhp_pkg::FRAC_WIDTH-1:0]  push_frac,
   output logic [VALUE_WIDTH-1:0]          push_value
);
   import lhp_pkg::*;

   localparam logic [VALUE_WIDTH-1:0] VMAX       = '1;
   localparam logic [VALUE_WIDTH-1:0] VMAX_TENTH = VMAX / 10;

   front_state_type         state_ff, state_in;
   opcode_type              op_ff;
   logic [VALUE_WIDTH-1:0]  value_ff;
   logic [FRAC_WIDTH-1:0]   frac_ff;
   logic [EXP_WIDTH-1:0]    exp_ff;
   logic [IDX_WIDTH-1:0]    lo_ff, hi_ff;

   logic [IDX_WIDTH:0]      mid_sum;
   logic [IDX_WIDTH-1:0]    mid;
   logic                    below;
   logic [VALUE_WIDTH-1:0]  times10;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[IDX_WIDTH:1];
   assign below   = VALUE_WIDTH'(bound_at(mid)) < value_ff;
   assign times10 = (value_ff << 3) + (value_ff << 1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               state_in = (opcode_type'(req_opcode) == OP_ADD) ? F_SCALE : F_PUSH;
            end
         end
         F_SCALE: begin
            if (exp_ff == '0) state_in = F_SEARCH;
         end
         F_SEARCH: begin
            if (lo_ff == hi_ff) state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!push_full) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = (state_ff == F_IDLE);
      push_valid = (state_ff == F_PUSH);
      push_op    = op_ff;
      push_idx   = lo_ff;
      push_frac  = frac_ff;
      push_value = value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         F_IDLE: begin
            op_ff    <= opcode_type'(req_opcode);
            value_ff <= VALUE_WIDTH'(req_sample);
            frac_ff  <= req_percentile_fraction;
            exp_ff   <= scale_exponent;
            lo_ff    <= '0;
            hi_ff    <= IDX_WIDTH'(NUM_FINITE);
         end
         F_SCALE: begin
            // multiply by ten once a cycle, pinning at full scale
            if (exp_ff != '0) begin
               value_ff <= (value_ff > VMAX_TENTH) ? VMAX : times10;
               exp_ff   <= exp_ff - 1'b1;
            end
         end
         F_SEARCH: begin
            if (lo_ff != hi_ff) begin
               if (below) begin
                  lo_ff <= mid + 1'b1;
               end else begin
                  hi_ff <= mid;
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/lhp_queue.sv
// two-entry queue between the front end and the back end
`timescale 1ns / 1ps
`default_nettype none

module lhp_queue #(
   parameter int WIDTH = 75
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push_valid,
   input  wire  [WIDTH-1:0] push_data,
   output logic             full,
   output logic             pop_valid,
   input  wire              pop,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= ~wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= ~rd_ptr_ff;
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

FILE: rtl/lhp_back.sv
// back end: bucket count memory, running statistics and percentile walk
`timescale 1ns / 1ps
`default_nettype none

module lhp_back #(
   parameter int VALUE_WIDTH = 48,
   parameter int COUNT_WIDTH = 32
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            q_valid,
   output logic                           q_pop,
   input  wire  [lhp_pkg::OP_WIDTH-1:0]   q_op,
   input  wire  [lhp_pkg::IDX_WIDTH-1:0]  q_idx,
   input  wire  [lhp_pkg::FRAC_WIDTH-1:0] q_frac,
   input  wire  [VALUE_WIDTH-1:0]         q_value,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output logic [lhp_pkg::IDX_WIDTH-1:0]  rsp_bucket_index,
   output logic [VALUE_WIDTH-1:0]         rsp_percentile_value,
   output logic [VALUE_WIDTH-1:0]         rsp_min_value,
   output logic [VALUE_WIDTH-1:0]         rsp_max_value,
   output logic [COUNT_WIDTH-1:0]         rsp_sample_count,
   output logic [lhp_pkg::SUM_WIDTH-1:0]  rsp_total_sum
);
   import lhp_pkg::*;

   localparam int CUM_WIDTH = COUNT_WIDTH + 8;
   localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
   localparam logic [VALUE_WIDTH-1:0] VMAX = '1;

   back_state_type          state_ff, state_in;
   opcode_type              op_ff;
   logic [IDX_WIDTH-1:0]    idx_ff;
   logic [FRAC_WIDTH-1:0]   frac_ff;
   logic [VALUE_WIDTH-1:0]  value_ff;

   logic [VALUE_WIDTH-1:0]  min_ff, max_ff;
   logic [SUM_WIDTH-1:0]    sum_ff;
   logic [COUNT_WIDTH-1:0]  count_ff;

   logic [COUNT_WIDTH-1:0]  count_mem [NUM_BUCKETS];
   logic [NUM_BUCKETS-1:0]  valid_ff;
   logic [COUNT_WIDTH-1:0]  rd_data_ff;
   logic                    rd_hit_ff;
   logic [IDX_WIDTH-1:0]    rd_addr;
   logic                    mem_we;

   logic [COUNT_WIDTH-1:0]  thr_ff;
   logic [CUM_WIDTH-1:0]    cum_ff;
   logic [IDX_WIDTH-1:0]    walk_ff;

   logic [DIV_STEPS-1:0]    a_ff;
   logic [DIV_STEPS-1:0]    quot_ff;
   logic [COUNT_WIDTH-1:0]  num_ff, den_ff, rem_ff;
   logic [STEP_WIDTH-1:0]   step_ff;
   logic [BOUND_WIDTH-1:0]  lo_ff;

   logic [IDX_WIDTH-1:0]    bidx_ff;
   logic [VALUE_WIDTH-1:0]  pct_ff;

   logic                    rsp_valid_ff;
   logic [IDX_WIDTH-1:0]    rsp_idx_ff;
   logic [VALUE_WIDTH-1:0]  rsp_pct_ff, rsp_min_ff, rsp_max_ff;
   logic [COUNT_WIDTH-1:0]  rsp_count_ff;
   logic [SUM_WIDTH-1:0]    rsp_sum_ff;
   logic                    out_load;

   logic [COUNT_WIDTH-1:0]  cnt;
   logic [CUM_WIDTH-1:0]    cum_new;
   logic                    hit;
   logic [BOUND_WIDTH-1:0]  lo_bound, hi_bound;
   logic [SUM_WIDTH:0]      sum_wide;
   logic [COUNT_WIDTH+FRAC_WIDTH-1:0] thr_prod;
   logic [FRAC_WIDTH-1:0]   frac_sat;

   // one step of the shift-and-subtract divider, which also multiplies by the bucket width
   logic [COUNT_WIDTH:0]    r_shift, r_first, r_add, r_next;
   logic                    inc_first, inc_add;
   logic [DIV_STEPS:0]      quot_next;

   assign cnt      = rd_hit_ff ? rd_data_ff : '0;
   assign cum_new  = cum_ff + CUM_WIDTH'(cnt);
   assign hit      = cum_new >= CUM_WIDTH'(thr_ff);
   assign lo_bound = (walk_ff == '0) ? '0 : bound_at(walk_ff - 1'b1);
   assign hi_bound = bound_at(walk_ff);
   assign sum_wide = {1'b0, sum_ff} + (SUM_WIDTH + 1)'(value_ff);
   assign frac_sat = (frac_ff > FRAC_ONE) ? FRAC_ONE : frac_ff;
   assign thr_prod = COUNT_WIDTH'(count_ff) * frac_sat;

   always_comb begin
      r_shift   = {rem_ff, 1'b0};
      inc_first = r_shift >= {1'b0, den_ff};
      r_first   = inc_first ? (r_shift - {1'b0, den_ff}) : r_shift;
      r_add     = a_ff[DIV_STEPS-1] ? (r_first + {1'b0, num_ff}) : r_first;
      inc_add   = r_add >= {1'b0, den_ff};
      r_next    = inc_add ? (r_add - {1'b0, den_ff}) : r_add;
      quot_next = {quot_ff, 1'b0} + (DIV_STEPS + 1)'(inc_first) +
                  (DIV_STEPS + 1)'(inc_add);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               unique case (opcode_type'(q_op))
                  OP_ADD:   state_in = B_ADD;
                  OP_QUERY: state_in = B_THR;
                  default:  state_in = B_EMIT;
               endcase
            end
         end
         B_ADD: state_in = B_EMIT;
         B_THR: state_in = B_RD;
         B_RD:  state_in = B_CHK;
         B_CHK: begin
            if (hit) begin
               if (walk_ff >= IDX_WIDTH'(NUM_FINITE) || cnt == '0) begin
                  state_in = B_FIN;
               end else begin
                  state_in = B_DIV;
               end
            end else if (walk_ff == IDX_WIDTH'(NUM_BUCKETS - 1)) begin
               state_in = B_EMIT;
            end else begin
               state_in = B_RD;
            end
         end
         B_DIV: begin
            if (step_ff == '0) state_in = B_FIN;
         end
         B_FIN: state_in = B_EMIT;
         B_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      q_pop    = (state_ff == B_IDLE) && q_valid;
      mem_we   = (state_ff == B_ADD);
      out_load = (state_ff == B_EMIT) && (!rsp_valid_ff || rsp_ready);
      rd_addr  = (state_ff == B_IDLE) ? q_idx : walk_ff;
   end

   // count memory: a clear drops the valid flags, so stale rows read as zero
   always_ff @(posedge clock) begin
      if (mem_we) begin
         count_mem[idx_ff] <= (cnt == CMAX) ? cnt : cnt + 1'b1;
      end
      rd_data_ff <= count_mem[rd_addr];
      rd_hit_ff  <= valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         valid_ff     <= '0;
         min_ff       <= VMAX;
         max_ff       <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (q_pop && opcode_type'(q_op) == OP_CLEAR) begin
            valid_ff <= '0;
            min_ff   <= VMAX;
            max_ff   <= '0;
            sum_ff   <= '0;
            count_ff <= '0;
         end
         if (mem_we) begin
            valid_ff[idx_ff] <= 1'b1;
            if (count_ff != CMAX) count_ff <= count_ff + 1'b1;
            if (value_ff < min_ff) min_ff <= value_ff;
            if (value_ff > max_ff) max_ff <= value_ff;
            sum_ff <= sum_wide[SUM_WIDTH] ? '1 : sum_wide[SUM_WIDTH-1:0];
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            op_ff    <= opcode_type'(q_op);
            idx_ff   <= q_idx;
            frac_ff  <= q_frac;
            value_ff <= q_value;
            bidx_ff  <= (opcode_type'(q_op) == OP_ADD) ? q_idx : '0;
            pct_ff   <= '0;
         end
         B_THR: begin
            thr_ff  <= thr_prod[COUNT_WIDTH+15:16];
            cum_ff  <= '0;
            walk_ff <= '0;
         end
         B_CHK: begin
            if (hit) begin
               if (walk_ff >= IDX_WIDTH'(NUM_FINITE)) begin
                  pct_ff <= max_ff;
               end else if (cnt == '0) begin
                  pct_ff <= VALUE_WIDTH'(lo_bound);
               end else begin
                  a_ff    <= DIV_STEPS'(hi_bound - lo_bound);
                  num_ff  <= COUNT_WIDTH'(CUM_WIDTH'(thr_ff) - cum_ff);
                  den_ff  <= cnt;
                  rem_ff  <= '0;
                  quot_ff <= '0;
                  step_ff <= STEP_WIDTH'(DIV_STEPS);
                  lo_ff   <= lo_bound;
               end
            end else if (walk_ff == IDX_WIDTH'(NUM_BUCKETS - 1)) begin
               // counts saturated and the walk ran off the end
               pct_ff <= max_ff;
            end else begin
               walk_ff <= walk_ff + 1'b1;
               cum_ff  <= cum_new;
            end
         end
         B_DIV: begin
            if (step_ff == '0) begin
               pct_ff <= VALUE_WIDTH'(lo_ff) + VALUE_WIDTH'(quot_ff);
            end else begin
               rem_ff  <= r_next[COUNT_WIDTH-1:0];
               quot_ff <= quot_next[DIV_STEPS-1:0];
               a_ff    <= {a_ff[DIV_STEPS-2:0], 1'b0};
               step_ff <= step_ff - 1'b1;
            end
         end
         B_FIN: begin
            if (pct_ff < min_ff) begin
               pct_ff <= min_ff;
            end else if (pct_ff > max_ff) begin
               pct_ff <= max_ff;
            end
         end
         default: begin
         end
      endcase
      if (out_load) begin
         rsp_idx_ff   <= bidx_ff;
         rsp_pct_ff   <= (op_ff == OP_QUERY) ? pct_ff : '0;
         rsp_min_ff   <= min_ff;
         rsp_max_ff   <= max_ff;
         rsp_count_ff <= count_ff;
         rsp_sum_ff   <= sum_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_bucket_index     = rsp_idx_ff;
   assign rsp_percentile_value = rsp_pct_ff;
   assign rsp_min_value        = rsp_min_ff;
   assign rsp_max_value        = rsp_max_ff;
   assign rsp_sample_count     = rsp_count_ff;
   assign rsp_total_sum        = rsp_sum_ff;

   a_div_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_DIV |-> den_ff != '0)
      else $error("divider running with a zero bucket count");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_CHK |-> walk_ff < IDX_WIDTH'(NUM_BUCKETS))
      else $error("percentile walk beyond last bucket");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 |-> min_ff <= max_ff)
      else $error("running min above running max with samples present");

endmodule

`default_nettype wire

FILE: rtl/latency_histogram_percentile.sv
// top level: config register, front end, queue and back end of the histogram
// add: the front end scales the sample by scale_exponent decades and searches its bucket
// clear and unused opcode: the result carries the statistics only
// query: the back end walks the buckets (up to 155), then divides inside a finite nonzero bucket
// the front end takes a new item only once the last one is pushed to the queue, back walk dominates
// sync active-high reset empties the histogram at once through per-bucket valid flags
// no clearing pass, scale_exponent resets to zero
`timescale 1ns / 1ps
`default_nettype none

module latency_histogram_percentile #(
   parameter int VALUE_WIDTH = 48,
   parameter int COUNT_WIDTH = 32
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire  [lhp_pkg::OP_WIDTH-1:0]    req_opcode,
   input  wire  [31:0]                     req_sample,
   input  wire  [lhp_pkg::FRAC_WIDTH-1:0]  req_percentile_fraction,
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output logic [lhp_pkg::IDX_WIDTH-1:0]   rsp_bucket_index,
   output logic [VALUE_WIDTH-1:0]          rsp_percentile_value,
   output logic [VALUE_WIDTH-1:0]          rsp_min_value,
   output logic [VALUE_WIDTH-1:0]          rsp_max_value,
   output logic [COUNT_WIDTH-1:0]          rsp_sample_count,
   output logic [lhp_pkg::SUM_WIDTH-1:0]   rsp_total_sum,
   input  wire                             csr_psel,
   input  wire                             csr_penable,
   input  wire                             csr_pwrite,
   input  wire  [lhp_pkg::CSR_AWIDTH-1:0]  csr_paddr,
   input  wire  [lhp_pkg::CSR_DWIDTH-1:0]  csr_pwdata,
   output logic [lhp_pkg::CSR_DWIDTH-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import lhp_pkg::*;

   localparam int ENTRY_WIDTH = OP_WIDTH + IDX_WIDTH + FRAC_WIDTH + VALUE_WIDTH;

   logic [EXP_WIDTH-1:0]   exp_ff;
   logic                   csr_hit;

   logic                   push_valid, push_full, pop_valid, pop;
   logic [OP_WIDTH-1:0]    push_op;
   logic [IDX_WIDTH-1:0]   push_idx;
   logic [FRAC_WIDTH-1:0]  push_frac;
   logic [VALUE_WIDTH-1:0] push_value;
   logic [ENTRY_WIDTH-1:0] push_data, pop_data;

   // register index sits above the byte offset
   assign csr_hit    = (csr_paddr[CSR_AWIDTH-1] == CSR_SCALE);
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? CSR_DWIDTH'(exp_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         exp_ff <= csr_pwdata[EXP_WIDTH-1:0];
      end
   end

   lhp_front #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_front (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_opcode              (req_opcode),
      .req_sample              (req_sample),
      .req_percentile_fraction (req_percentile_fraction),
      .scale_exponent          (exp_ff),
      .push_full               (push_full),
      .push_valid              (push_valid),
      .push_op                 (push_op),
      .push_idx                (push_idx),
      .push_frac               (push_frac),
      .push_value              (push_value)
   );

   assign push_data = {push_op, push_idx, push_frac, push_value};

   lhp_queue #(
      .WIDTH(ENTRY_WIDTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (push_full),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_data   (pop_data)
   );

   lhp_back #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .q_valid              (pop_valid),
      .q_pop                (pop),
      .q_op                 (pop_data[ENTRY_WIDTH-1 -: OP_WIDTH]),
      .q_idx                (pop_data[ENTRY_WIDTH-OP_WIDTH-1 -: IDX_WIDTH]),
      .q_frac               (pop_data[VALUE_WIDTH+FRAC_WIDTH-1 -: FRAC_WIDTH]),
      .q_value              (pop_data[VALUE_WIDTH-1:0]),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_bucket_index     (rsp_bucket_index),
      .rsp_percentile_value (rsp_percentile_value),
      .rsp_min_value        (rsp_min_value),
      .rsp_max_value        (rsp_max_value),
      .rsp_sample_count     (rsp_sample_count),
      .rsp_total_sum        (rsp_total_sum)
   );

endmodule

`default_nettype wire

FILE: test/latency_histogram_percentile_tb.sv
// testbench for the latency histogram: directed and random traffic against a local predictor
`timescale 1ns / 1ps

module latency_histogram_percentile_tb;
   import lhp_pkg::*;

   localparam longint unsigned VALUE_MAX = 64'h0000_FFFF_FFFF_FFFF;
   localparam logic [31:0]     COUNT_MAX = 32'hFFFF_FFFF;
   localparam logic [2:0]      ADDR_SCALE = 3'd0;

   typedef struct {
      logic [7:0]  bucket;
      logic [47:0] pct;
      logic [47:0] min_v;
      logic [47:0] max_v;
      logic [31:0] count;
      logic [63:0] sum;
   } hist_stats_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_opcode;
   logic [31:0] req_sample;
   logic [16:0] req_percentile_fraction;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_bucket_index;
   logic [47:0] rsp_percentile_value;
   logic [47:0] rsp_min_value;
   logic [47:0] rsp_max_value;
   logic [31:0] rsp_sample_count;
   logic [63:0] rsp_total_sum;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor state
   logic [31:0]     bin_count [NUM_BUCKETS];
   longint unsigned low_mark;
   longint unsigned high_mark;
   longint unsigned sum_acc;
   logic [31:0]     n_samples;
   logic [3:0]      decade_shift;

   hist_stats_type expected_stats[$];
   int             fail_count;
   int             send_idle_pct;
   int             recv_stall_pct;

   latency_histogram_percentile dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_sample(req_sample), .req_percentile_fraction(req_percentile_fraction),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_bucket_index(rsp_bucket_index),
      .rsp_percentile_value(rsp_percentile_value), .rsp_min_value(rsp_min_value),
      .rsp_max_value(rsp_max_value), .rsp_sample_count(rsp_sample_count),
      .rsp_total_sum(rsp_total_sum),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("latency_histogram_percentile_tb failed");
      $finish;
   end

   function automatic longint unsigned bucket_edge(input int i);
      longint unsigned mant [16] = '{10, 12, 14, 16, 18, 20, 25, 30, 35, 40, 45, 50,
                                     60, 70, 80, 90};
      longint unsigned v;
      if (i < 9) begin
         return i + 1;
      end
      v = mant[(i - 9) % 16];
      for (int k = 0; k < (i - 9) / 16; k++) v = v * 10;
      return v;
   endfunction

   function automatic void empty_histogram();
      foreach (bin_count[i]) bin_count[i] = '0;
      low_mark  = VALUE_MAX;
      high_mark = 0;
      sum_acc   = 0;
      n_samples = '0;
   endfunction

   function automatic logic [47:0] percentile_of(input logic [16:0] frac);
      longint unsigned fr, thr, cum, cnt, lo, hi, r;
      logic [127:0]    prod;
      bit              hit;
      fr  = (frac > FRAC_ONE) ? 64'd65536 : 64'(frac);
      thr = (64'(n_samples) * fr) >> 16;
      cum = 0;
      r   = high_mark;
      hit = 0;
      for (int b = 0; b < NUM_BUCKETS && !hit; b++) begin
         cnt = bin_count[b];
         cum = cum + cnt;
         if (cum >= thr) begin
            hit = 1;
            if (b >= NUM_FINITE) begin
               r = high_mark;
            end else begin
               lo = (b > 0) ? bucket_edge(b - 1) : 0;
               hi = bucket_edge(b);
               if (cnt == 0) begin
                  r = lo;
               end else begin
                  prod = 128'(hi - lo) * 128'(thr - (cum - cnt));
                  r = lo + 64'(prod / 128'(cnt));
               end
            end
            if (r < low_mark) r = low_mark;
            else if (r > high_mark) r = high_mark;
         end
      end
      return r[47:0];
   endfunction

   function automatic hist_stats_type predict_histogram_step(input opcode_type op,
         input logic [31:0] raw, input logic [16:0] frac);
      hist_stats_type  res;
      longint unsigned v;
      int              idx;
      res.bucket = '0;
      res.pct    = '0;
      case (op)
         OP_ADD: begin
            v = raw;
            for (int k = 0; k < decade_shift; k++)
               v = (v > VALUE_MAX / 10) ? VALUE_MAX : v * 10;
            idx = 0;
            for (int i = 0; i < NUM_FINITE; i++) if (bucket_edge(i) < v) idx++;
            if (bin_count[idx] != COUNT_MAX) bin_count[idx]++;
            if (n_samples != COUNT_MAX) n_samples++;
            if (v < low_mark) low_mark = v;
            if (v > high_mark) high_mark = v;
            sum_acc = (sum_acc > ~64'd0 - v) ? ~64'd0 : sum_acc + v;
            res.bucket = idx[7:0];
         end
         OP_CLEAR: empty_histogram();
         OP_QUERY: res.pct = percentile_of(frac);
         default: ;
      endcase
      res.min_v = low_mark[47:0];
      res.max_v = high_mark[47:0];
      res.count = n_samples;
      res.sum   = sum_acc;
      return res;
   endfunction

   // response side: random back-pressure, checked at the rising edge
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   task automatic check_field(input string name, input logic [63:0] want,
         input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      hist_stats_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_stats.size() == 0) begin
            $display("%0t: unexpected result transfer, expected none, actual bucket %0d",
                     $time, rsp_bucket_index);
            fail_count++;
         end else begin
            e = expected_stats.pop_front();
            check_field("bucket_index", e.bucket, rsp_bucket_index);
            check_field("percentile_value", e.pct, rsp_percentile_value);
            check_field("min_value", e.min_v, rsp_min_value);
            check_field("max_value", e.max_v, rsp_max_value);
            check_field("sample_count", e.count, rsp_sample_count);
            check_field("total_sum", e.sum, rsp_total_sum);
         end
      end
   end

   task automatic send_item(input opcode_type op, input logic [31:0] raw,
         input logic [16:0] frac);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid  = 1'b1;
      req_opcode = op;
      req_sample = raw;
      req_percentile_fraction = frac;
      do @(posedge clock); while (!req_ready);
      expected_stats.push_back(predict_histogram_step(op, raw, frac));
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_stats.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_scale(input logic [31:0] value);
      drain();
      @(negedge clock);
      csr_psel = 1'b1; csr_pwrite = 1'b1; csr_paddr = ADDR_SCALE; csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      decade_shift = value[3:0];
   endtask

   task automatic test_edge_samples();
      send_item(OP_QUERY, 32'd0, FRAC_ONE);       // empty histogram answers all ones
      send_item(OP_ADD, 32'd0, 17'd0);
      send_item(OP_ADD, 32'd1, 17'd0);
      send_item(OP_ADD, 32'd10, 17'd0);
      send_item(OP_ADD, 32'hFFFF_FFFF, 17'd0);     // largest sample, still below the top finite bound
      send_item(OP_QUERY, 32'd0, 17'd0);           // zero fraction stops in the first bucket
      send_item(OP_QUERY, 32'hFFFF_FFFF, 17'h1FFFF); // fraction above one
      send_item(OP_QUERY, 32'd0, 17'd32768);
      send_item(OP_NONE, 32'hFFFF_FFFF, 17'h1FFFF);
      send_item(OP_CLEAR, 32'd0, 17'd0);
      send_item(OP_QUERY, 32'd0, 17'd32768);
   endtask

   task automatic test_scale_extremes();
      write_scale(32'd9);
      send_item(OP_ADD, 32'd1, 17'd0);
      send_item(OP_ADD, 32'hFFFF_FFFF, 17'd0);     // saturates the value
      send_item(OP_QUERY, 32'd0, FRAC_ONE);        // top bucket answers max
      write_scale(32'd15);                         // exponent above nine
      send_item(OP_ADD, 32'd3, 17'd0);
      send_item(OP_QUERY, 32'd0, 17'd40000);
      send_item(OP_CLEAR, 32'd0, 17'd0);
      write_scale(32'd0);
      for (int i = 0; i < 6; i++) send_item(OP_ADD, 32'd1 << (i * 5), 17'd0);
      send_item(OP_QUERY, 32'd0, 17'd1);
      send_item(OP_QUERY, 32'd0, 17'd65535);
   endtask

   task automatic test_pause_until_empty();
      for (int i = 0; i < 6; i++) begin
         send_item(opcode_type'(i % 3), $urandom >> $urandom_range(0, 31),
                   17'($urandom_range(0, 65536)));
         drain();
      end
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
         input logic [31:0] scale, input int n);
      int         sel;
      opcode_type op;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_scale(scale);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 99);
         op  = (sel < 84) ? OP_ADD : (sel < 95) ? OP_QUERY : (sel < 97) ? OP_CLEAR : OP_NONE;
         send_item(op, $urandom >> $urandom_range(0, 31),
                   ($urandom_range(0, 9) == 0) ? 17'($urandom) :
                                                 17'($urandom_range(0, 65536)));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0; req_opcode = OP_ADD; req_sample = '0; req_percentile_fraction = '0;
      rsp_ready = 1'b0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0; csr_paddr = '0; csr_pwdata = '0;
      fail_count = 0; send_idle_pct = 0; recv_stall_pct = 0;
      decade_shift = '0;
      empty_histogram();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_edge_samples();
      test_scale_extremes();
      test_pause_until_empty();
      test_random_traffic(0, 0, 32'd0, 220);
      test_random_traffic(46, 0, 32'd3, 220);
      test_random_traffic(0, 46, 32'd9, 220);
      test_random_traffic(30, 30, 32'($urandom_range(0, 15)), 220);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("latency_histogram_percentile_tb passed");
      end else begin
         $display("latency_histogram_percentile_tb failed");
      end
      $finish;
   end

endmodule

FILE: latency_histogram_percentile.f
rtl/lhp_pkg.sv
rtl/lhp_front.sv
rtl/lhp_queue.sv
rtl/lhp_back.sv
rtl/latency_histogram_percentile.sv
test/latency_histogram_percentile_tb.sv
